// ===== rtl/dmc_pkg.sv =====
package dmc_pkg;

    localparam int CFG_W   = 6;
    localparam int DRAW_W  = 16;
    localparam int COORD_W = 6;
    localparam int DIVS_W  = 8;

    localparam int MAX_SIDE_DEF    = 63;
    localparam int STACK_DEPTH_DEF = 2048;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [2:0] ST_STARTED  = 3'd0;
    localparam logic [2:0] ST_MOVED    = 3'd1;
    localparam logic [2:0] ST_BACK     = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;
    localparam logic [2:0] ST_IGNORED  = 3'd6;

    typedef struct packed {
        logic              start;
        logic [DRAW_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== rtl/dmc_div.sv =====
module dmc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dmc_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [dmc_pkg::DIVS_W-1:0]  o_rem
);
    import dmc_pkg::*;

    localparam int CNT_W = $clog2(DRAW_W + 1);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DRAW_W-1:0] r_num, n_num;
    logic [DIVS_W-1:0] r_den, n_den;
    logic [DIVS_W-1:0] r_rem, n_rem;
    logic [DIVS_W:0]   trial;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        trial  = {r_rem, r_num[DRAW_W-1]};
        if (!r_busy && i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_req.dividend;
            n_den  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DIVS_W'(trial - {1'b0, r_den});
            end else begin
                n_rem = DIVS_W'(trial);
            end
            n_num = {r_num[DRAW_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DRAW_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/dfs_maze_carver_top.sv =====
// channel | direction | handshake           | payload
// in      | input     | i_in_valid/o_in_stall   | action, axes, sides, draws, row, col
// out     | output    | o_out_valid/i_out_stall | status, pos_x, pos_y, wall
// cfg     | input     | i_cfg_valid/o_cfg_ready | side_length
// one transaction at a time; a read loads the result after its grid read, a step after
// up to four grid reads, a remainder run and one grid write per carved cell; a reject, an
// ignored item or a read outside the maze loads it straight from the idle state
// a start takes two remainder runs plus a grid fill, one cell a cycle
// all grid reads and writes go through the single grid port; reset needs no clearing pass
// the result register frees the input side: a new transaction is taken while it waits
// synchronous active-low reset clears control state only
module dfs_maze_carver_top #(
    parameter int MAX_SIDE    = dmc_pkg::MAX_SIDE_DEF,
    parameter int STACK_DEPTH = dmc_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic                          i_start_axis,
    input  logic                          i_start_side,
    input  logic                          i_end_axis,
    input  logic                          i_end_side,
    input  logic [dmc_pkg::DRAW_W-1:0]    i_start_draw,
    input  logic [dmc_pkg::DRAW_W-1:0]    i_end_draw,
    input  logic [dmc_pkg::DRAW_W-1:0]    i_move_draw,
    input  logic [dmc_pkg::COORD_W-1:0]   i_row,
    input  logic [dmc_pkg::COORD_W-1:0]   i_col,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [dmc_pkg::COORD_W-1:0]   o_pos_x,
    output logic [dmc_pkg::COORD_W-1:0]   o_pos_y,
    output logic                          o_wall,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dmc_pkg::CFG_W-1:0]     i_cfg_side_length
);
    import dmc_pkg::*;

    localparam int CW       = $clog2(MAX_SIDE + 1);
    localparam int SW       = CW + 2;
    localparam int CMP_W    = 10;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int GAW      = $clog2(CELLS);
    localparam int SAW      = $clog2(STACK_DEPTH);
    localparam int CNW      = $clog2(STACK_DEPTH + 1);
    localparam int MAX_ODD  = (MAX_SIDE % 2 == 0) ? MAX_SIDE - 1 : MAX_SIDE;

    localparam logic [1:0] CELL_OPEN = 2'b10;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_DIVS   = 16'h0002,
        S_DIVE   = 16'h0004,
        S_FILL   = 16'h0008,
        S_OPEN_S = 16'h0010,
        S_OPEN_E = 16'h0020,
        S_NRD    = 16'h0040,
        S_NCHK   = 16'h0080,
        S_NEVAL  = 16'h0100,
        S_DIVM   = 16'h0200,
        S_MOVE   = 16'h0400,
        S_HEAD   = 16'h0800,
        S_HEADW  = 16'h1000,
        S_RD     = 16'h2000,
        S_RDW    = 16'h4000,
        S_DONE   = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_side_length;
    logic [CW-1:0]     r_side, n_side;
    logic              r_started, n_started;
    logic              r_running, n_running;
    logic              r_first, n_first;
    logic [CNW-1:0]    r_count, n_count;
    logic [CW-1:0]     r_head_x, n_head_x, r_head_y, n_head_y;

    logic              r_s_axis, r_s_side, r_e_axis, r_e_side;
    logic [DRAW_W-1:0] r_s_draw, r_e_draw, r_m_draw;
    logic [COORD_W-1:0] r_row, r_col;

    logic [CW-1:0]     r_s_along, n_s_along, r_e_along, n_e_along;
    logic [CW-1:0]     r_fr, n_fr, r_fc, n_fc;
    logic [1:0]        r_dir, n_dir;
    logic [3:0]        r_cand, n_cand;
    logic              r_was_first, n_was_first;
    logic [1:0]        r_pick, n_pick;
    logic              r_mv, n_mv;
    logic              r_div_sent, n_div_sent;

    logic [2:0]        r_res_status, n_res_status;
    logic              r_res_wall, n_res_wall;

    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_status, n_out_status;
    logic [COORD_W-1:0] r_out_x, n_out_x, r_out_y, n_out_y;
    logic              r_out_wall, n_out_wall;

    logic [1:0]        grid_mem [CELLS];
    logic [1:0]        r_gq;
    logic [2*CW-1:0]   stk_mem [STACK_DEPTH];
    logic [2*CW-1:0]   r_sq;

    logic              g_we;
    logic [CW-1:0]     g_x, g_y;
    logic [GAW-1:0]    g_addr;
    logic [1:0]        g_wdata;
    logic              s_we;
    logic [SAW-1:0]    s_waddr, s_raddr;
    logic [2*CW-1:0]   s_wdata;

    t_div_req          div_req;
    logic              div_done;
    logic [DIVS_W-1:0] div_rem;

    logic              in_acc;
    logic [CMP_W-1:0]  clamp_v;
    logic [DIVS_W-1:0] k_val;
    logic [CW-1:0]     s_x, s_y, e_x, e_y;
    logic signed [SW-1:0] nb_x, nb_y, lim_s;
    logic              nb_ok;
    logic [2:0]        cand_n;
    logic              steps2;
    logic [CW-1:0]     mv_x, mv_y;
    logic [1:0]        sel_dir;
    logic [2:0]        seen_n;

    dmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // clamp side, widened so any MAX_SIDE fits
    always_comb begin
        clamp_v = CMP_W'(r_side_length);
        if (clamp_v < CMP_W'(5)) begin
            clamp_v = CMP_W'(5);
        end else if (!clamp_v[0]) begin
            clamp_v = clamp_v - 1'b1;
        end
        if (clamp_v > CMP_W'(MAX_SIDE)) begin
            clamp_v = CMP_W'(MAX_ODD);
        end
    end

    assign k_val = DIVS_W'((({1'b0, r_side} + 1'b1) >> 1) - 2'd2);

    // opening coordinates
    always_comb begin
        if (r_s_axis) begin
            s_x = r_s_side ? (r_side - 1'b1) : '0;
            s_y = r_s_along;
        end else begin
            s_x = r_s_along;
            s_y = r_s_side ? (r_side - 1'b1) : '0;
        end
        if (r_e_axis) begin
            e_x = r_e_side ? (r_side - 1'b1) : '0;
            e_y = r_e_along;
        end else begin
            e_x = r_e_along;
            e_y = r_e_side ? (r_side - 1'b1) : '0;
        end
    end

    // neighbor two cells away in direction r_dir (up, down, left, right)
    always_comb begin
        nb_x  = $signed({2'b00, r_head_x});
        nb_y  = $signed({2'b00, r_head_y});
        lim_s = $signed({2'b00, r_side}) - SW'(1);
        case (r_dir)
            2'd0:    nb_y = nb_y - SW'(2);
            2'd1:    nb_y = nb_y + SW'(2);
            2'd2:    nb_x = nb_x - SW'(2);
            default: nb_x = nb_x + SW'(2);
        endcase
        nb_ok = (nb_x > 0) && (nb_x < lim_s) && (nb_y > 0) && (nb_y < lim_s);
    end

    // one-cell move toward the picked direction
    always_comb begin
        mv_x = r_head_x;
        mv_y = r_head_y;
        case (r_pick)
            2'd0:    mv_y = r_head_y - 1'b1;
            2'd1:    mv_y = r_head_y + 1'b1;
            2'd2:    mv_x = r_head_x - 1'b1;
            default: mv_x = r_head_x + 1'b1;
        endcase
    end

    assign cand_n = 3'(r_cand[0]) + 3'(r_cand[1]) + 3'(r_cand[2]) + 3'(r_cand[3]);
    assign steps2 = !r_first;

    // the div_rem-th set candidate bit
    always_comb begin
        sel_dir = 2'd0;
        seen_n  = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (r_cand[i]) begin
                if (seen_n == {1'b0, div_rem[1:0]}) begin
                    sel_dir = 2'(i);
                end
                seen_n = seen_n + 1'b1;
            end
        end
    end

    // grid port, stack port and divider request control
    always_comb begin
        g_we    = 1'b0;
        g_x     = r_fc;
        g_y     = r_fr;
        g_wdata = CELL_OPEN;
        s_we    = 1'b0;
        s_waddr = SAW'(r_count);
        s_wdata = {r_head_y, r_head_x};
        s_raddr = SAW'(r_count - 1'b1);
        div_req.start    = 1'b0;
        div_req.dividend = r_m_draw;
        div_req.divisor  = {{(DIVS_W-3){1'b0}}, cand_n};
        unique case (r_state)
            S_FILL: begin
                g_we    = 1'b1;
                g_wdata = {(r_fr == '0) || (r_fc == '0) || (r_fr == r_side - 1'b1)
                           || (r_fc == r_side - 1'b1), 1'b1};
            end
            S_OPEN_S: begin
                g_we    = 1'b1;
                g_x     = s_x;
                g_y     = s_y;
                s_we    = 1'b1;
                s_waddr = '0;
                s_wdata = {s_y, s_x};
            end
            S_OPEN_E: begin
                g_we = 1'b1;
                g_x  = e_x;
                g_y  = e_y;
            end
            S_NRD: begin
                g_x = CW'(nb_x);
                g_y = CW'(nb_y);
            end
            S_MOVE: begin
                g_we    = 1'b1;
                g_x     = mv_x;
                g_y     = mv_y;
                s_we    = 1'b1;
                s_wdata = {mv_y, mv_x};
            end
            S_RD: begin
                g_x = CW'(r_col);
                g_y = CW'(r_row);
            end
            S_DIVS: begin
                div_req.start    = !r_div_sent;
                div_req.dividend = r_s_draw;
                div_req.divisor  = k_val;
            end
            S_DIVE: begin
                div_req.start    = !r_div_sent;
                div_req.dividend = r_e_draw;
                div_req.divisor  = k_val;
            end
            S_DIVM: begin
                div_req.start = !r_div_sent;
            end
            default: begin
            end
        endcase
        g_addr = GAW'(GAW'(g_y) * GAW'(MAX_SIDE) + GAW'(g_x));
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            grid_mem[g_addr] <= g_wdata;
        end
        r_gq <= grid_mem[g_addr];
        if (s_we) begin
            stk_mem[s_waddr] <= s_wdata;
        end
        r_sq <= stk_mem[s_raddr];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_side       = r_side;
        n_started    = r_started;
        n_running    = r_running;
        n_first      = r_first;
        n_count      = r_count;
        n_head_x     = r_head_x;
        n_head_y     = r_head_y;
        n_s_along    = r_s_along;
        n_e_along    = r_e_along;
        n_fr         = r_fr;
        n_fc         = r_fc;
        n_dir        = r_dir;
        n_cand       = r_cand;
        n_was_first  = r_was_first;
        n_pick       = r_pick;
        n_mv         = r_mv;
        n_div_sent   = r_div_sent;
        n_res_status = r_res_status;
        n_res_wall   = r_res_wall;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_wall   = r_out_wall;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_wall = 1'b0;
                    n_div_sent = 1'b0;
                    n_dir      = 2'd0;
                    n_cand     = '0;
                    unique case (i_action)
                        ACT_START: begin
                            if (i_start_axis == i_end_axis && i_start_side == i_end_side) begin
                                n_res_status = ST_REJECTED;
                                n_state      = S_DONE;
                            end else begin
                                n_side  = CW'(clamp_v);
                                n_state = S_DIVS;
                            end
                        end
                        ACT_STEP: begin
                            if (r_running && r_count != '0) begin
                                n_state = S_NRD;
                            end else begin
                                n_res_status = ST_IGNORED;
                                n_state      = S_DONE;
                            end
                        end
                        ACT_READ: begin
                            n_res_status = ST_READ;
                            if (r_started && CMP_W'(i_row) < CMP_W'(r_side)
                                && CMP_W'(i_col) < CMP_W'(r_side)) begin
                                n_state = S_RD;
                            end else begin
                                n_res_wall = 1'b1;
                                n_state    = S_DONE;
                            end
                        end
                        default: begin
                            n_res_status = ST_IGNORED;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_DIVS: begin
                if (!r_div_sent) begin
                    n_div_sent = 1'b1;
                end else if (div_done) begin
                    n_div_sent = 1'b0;
                    n_s_along  = CW'({div_rem, 1'b1});
                    n_state    = S_DIVE;
                end
            end
            S_DIVE: begin
                if (!r_div_sent) begin
                    n_div_sent = 1'b1;
                end else if (div_done) begin
                    n_div_sent = 1'b0;
                    n_e_along  = CW'({div_rem, 1'b1});
                    n_fr       = '0;
                    n_fc       = '0;
                    n_state    = S_FILL;
                end
            end
            S_FILL: begin
                if (r_fc == r_side - 1'b1) begin
                    n_fc = '0;
                    n_fr = r_fr + 1'b1;
                    if (r_fr == r_side - 1'b1) begin
                        n_state = S_OPEN_S;
                    end
                end else begin
                    n_fc = r_fc + 1'b1;
                end
            end
            S_OPEN_S: begin
                n_count  = CNW'(1);
                n_head_x = s_x;
                n_head_y = s_y;
                n_state  = S_OPEN_E;
            end
            S_OPEN_E: begin
                n_first      = 1'b1;
                n_running    = 1'b1;
                n_started    = 1'b1;
                n_res_status = ST_STARTED;
                n_state      = S_DONE;
            end
            S_NRD: begin
                if (nb_ok) begin
                    n_state = S_NCHK;
                end else if (r_dir == 2'd3) begin
                    n_state = S_NEVAL;
                end else begin
                    n_dir = r_dir + 1'b1;
                end
            end
            S_NCHK: begin
                n_cand[r_dir] = !r_gq[1];
                if (r_dir == 2'd3) begin
                    n_state = S_NEVAL;
                end else begin
                    n_dir   = r_dir + 1'b1;
                    n_state = S_NRD;
                end
            end
            S_NEVAL: begin
                n_was_first = r_first;
                n_first     = 1'b0;
                if (r_cand != '0 && ({1'b0, r_count} + (CNW+1)'({steps2, !steps2}))
                    <= (CNW+1)'(STACK_DEPTH)) begin
                    n_state = S_DIVM;
                end else if (!r_first && r_count > CNW'(1)) begin
                    if (r_count - 1'b1 > CNW'(2)) begin
                        n_count      = r_count - CNW'(2);
                        n_res_status = ST_BACK;
                    end else begin
                        n_count      = r_count - 1'b1;
                        n_running    = 1'b0;
                        n_res_status = ST_FINISHED;
                    end
                    n_state = S_HEAD;
                end else begin
                    n_running    = 1'b0;
                    n_res_status = ST_FINISHED;
                    n_state      = S_DONE;
                end
            end
            S_DIVM: begin
                if (!r_div_sent) begin
                    n_div_sent = 1'b1;
                end else if (div_done) begin
                    n_div_sent = 1'b0;
                    n_pick     = sel_dir;
                    n_mv       = 1'b0;
                    n_state    = S_MOVE;
                end
            end
            S_MOVE: begin
                n_head_x = mv_x;
                n_head_y = mv_y;
                n_count  = r_count + 1'b1;
                if (r_was_first || r_mv) begin
                    n_res_status = ST_MOVED;
                    n_state      = S_DONE;
                end else begin
                    n_mv = 1'b1;
                end
            end
            S_HEAD: begin
                n_state = S_HEADW;
            end
            S_HEADW: begin
                n_head_x = r_sq[CW-1:0];
                n_head_y = r_sq[2*CW-1:CW];
                n_state  = S_DONE;
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                n_res_wall = r_gq[0];
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_wall   = r_res_wall;
                    n_out_x      = (r_count == '0) ? '0 : COORD_W'(r_head_x);
                    n_out_y      = (r_count == '0) ? '0 : COORD_W'(r_head_y);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_side_length <= CFG_W'(5);
            r_side        <= CW'(5);
            r_started     <= 1'b0;
            r_running     <= 1'b0;
            r_first       <= 1'b1;
            r_count       <= '0;
            r_div_sent    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_side_length <= i_cfg_side_length;
            end
            r_side        <= n_side;
            r_started     <= n_started;
            r_running     <= n_running;
            r_first       <= n_first;
            r_count       <= n_count;
            r_div_sent    <= n_div_sent;
            r_out_valid   <= n_out_valid;
        end
        if (in_acc) begin
            r_s_axis <= i_start_axis;
            r_s_side <= i_start_side;
            r_e_axis <= i_end_axis;
            r_e_side <= i_end_side;
            r_s_draw <= i_start_draw;
            r_e_draw <= i_end_draw;
            r_m_draw <= i_move_draw;
            r_row    <= i_row;
            r_col    <= i_col;
        end
        r_head_x     <= n_head_x;
        r_head_y     <= n_head_y;
        r_s_along    <= n_s_along;
        r_e_along    <= n_e_along;
        r_fr         <= n_fr;
        r_fc         <= n_fc;
        r_dir        <= n_dir;
        r_cand       <= n_cand;
        r_was_first  <= n_was_first;
        r_pick       <= n_pick;
        r_mv         <= n_mv;
        r_res_status <= n_res_status;
        r_res_wall   <= n_res_wall;
        r_out_status <= n_out_status;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_wall   <= n_out_wall;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_wall      = r_out_wall;

endmodule

// ===== tb/dfs_maze_carver_top_tb.sv =====
`timescale 1ns / 1ps

module dfs_maze_carver_top_tb;
    import dmc_pkg::*;

    localparam int GRID_SIDE  = MAX_SIDE_DEF;
    localparam int STK_DEPTH  = STACK_DEPTH_DEF;
    localparam int CYCLE_CAP  = 20000000;
    localparam int PER_SIDE   = 30;
    localparam logic [1:0] ACT_BOGUS = 2'd3;
    localparam logic [1:0] WALL_F = 2'b01;
    localparam logic [1:0] SEEN_F = 2'b10;

    typedef struct {
        logic [1:0]        action;
        logic              s_axis, s_side, e_axis, e_side;
        logic [DRAW_W-1:0] s_draw, e_draw, m_draw;
        logic [COORD_W-1:0] row, col;
    } maze_cmd_t;

    typedef struct {
        logic [2:0]         status;
        logic [COORD_W-1:0] px, py;
        logic               wall;
    } maze_resp_t;

    typedef struct {
        maze_cmd_t  cmd;
        bit         typed;
        maze_resp_t resp;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid, o_in_stall;
    logic [1:0] i_action;
    logic i_start_axis, i_start_side, i_end_axis, i_end_side;
    logic [DRAW_W-1:0] i_start_draw, i_end_draw, i_move_draw;
    logic [COORD_W-1:0] i_row, i_col;
    logic o_out_valid, i_out_stall;
    logic [2:0] o_status;
    logic [COORD_W-1:0] o_pos_x, o_pos_y;
    logic o_wall;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_side_length;

    dfs_maze_carver_top u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // carving model state
    logic [1:0] grid [GRID_SIDE*GRID_SIDE];
    int stk_x [STK_DEPTH];
    int stk_y [STK_DEPTH];
    int stk_cnt, act_side, side_reg;
    bit first_mv, carving;

    maze_resp_t pending_resp[$];
    int mismatches, n_checked, n_items, n_cfg;
    int n_status [8];
    int send_idle_pct, recv_idle_pct;
    int cycles;

    function automatic int clamp_side(int s);
        if (s < 5) s = 5;
        else if (s % 2 == 0) s--;
        if (s > GRID_SIDE) s = GRID_SIDE;
        return s;
    endfunction

    function automatic void place_open(logic axis, logic side, int draw,
                                       output int x, output int y);
        int k, along, across;
        k = (act_side + 1) / 2 - 2;
        along = 2 * (draw % k) + 1;
        across = side ? act_side - 1 : 0;
        if (axis == 1'b0) begin
            x = along; y = across;
        end else begin
            x = across; y = along;
        end
    endfunction

    function automatic void push_pos(int x, int y);
        if (stk_cnt < STK_DEPTH) begin
            stk_x[stk_cnt] = x;
            stk_y[stk_cnt] = y;
            stk_cnt++;
        end
    endfunction

    function automatic logic [2:0] carve_step(int draw);
        int dx [4] = '{0, 0, -1, 1};
        int dy [4] = '{-1, 1, 0, 0};
        int cand [4];
        int n, cx, cy, lim, steps, nx, ny, pick;
        bit was_first;
        n = 0;
        cx = stk_x[stk_cnt-1];
        cy = stk_y[stk_cnt-1];
        lim = act_side - 1;
        steps = first_mv ? 1 : 2;
        was_first = first_mv;
        first_mv = 1'b0;
        for (int d = 0; d < 4; d++) begin
            nx = cx + 2 * dx[d];
            ny = cy + 2 * dy[d];
            if (nx > 0 && nx < lim && ny > 0 && ny < lim &&
                (grid[ny*GRID_SIDE+nx] & SEEN_F) == 2'b00) begin
                cand[n] = d;
                n++;
            end
        end
        if (n > 0 && stk_cnt + steps <= STK_DEPTH) begin
            pick = cand[draw % n];
            for (int s = 0; s < steps; s++) begin
                cx += dx[pick];
                cy += dy[pick];
                push_pos(cx, cy);
                grid[cy*GRID_SIDE+cx] = SEEN_F;
            end
            return ST_MOVED;
        end
        if (!was_first && stk_cnt > 1) begin
            stk_cnt--;
            if (stk_cnt > 2) begin
                stk_cnt--;
                return ST_BACK;
            end
        end
        carving = 1'b0;
        return ST_FINISHED;
    endfunction

    function automatic maze_resp_t predict_carve(maze_cmd_t c);
        maze_resp_t r;
        int x, y;
        bit border;
        r = '{status: ST_IGNORED, px: '0, py: '0, wall: 1'b0};
        if (c.action == ACT_START) begin
            if (c.s_axis == c.e_axis && c.s_side == c.e_side) begin
                r.status = ST_REJECTED;
            end else begin
                act_side = clamp_side(side_reg);
                for (int rr = 0; rr < act_side; rr++)
                    for (int cc = 0; cc < act_side; cc++) begin
                        border = rr == 0 || cc == 0 || rr == act_side-1 || cc == act_side-1;
                        grid[rr*GRID_SIDE+cc] = border ? (WALL_F | SEEN_F) : WALL_F;
                    end
                stk_cnt = 0;
                place_open(c.s_axis, c.s_side, c.s_draw, x, y);
                push_pos(x, y);
                grid[y*GRID_SIDE+x] = SEEN_F;
                place_open(c.e_axis, c.e_side, c.e_draw, x, y);
                grid[y*GRID_SIDE+x] = SEEN_F;
                first_mv = 1'b1;
                carving = 1'b1;
                r.status = ST_STARTED;
            end
        end else if (c.action == ACT_STEP) begin
            if (carving && stk_cnt > 0) r.status = carve_step(c.m_draw);
        end else if (c.action == ACT_READ) begin
            r.status = ST_READ;
            if (c.row < act_side && c.col < act_side)
                r.wall = grid[c.row*GRID_SIDE+c.col][0];
            else
                r.wall = 1'b1;
        end
        if (stk_cnt > 0) begin
            r.px = COORD_W'(stk_x[stk_cnt-1]);
            r.py = COORD_W'(stk_y[stk_cnt-1]);
        end
        return r;
    endfunction

    function automatic maze_cmd_t mk_cmd(logic [1:0] a, logic sa, logic ss, logic ea, logic es,
                                         int sd, int ed, int md, int row, int col);
        maze_cmd_t c;
        c = '{action: a, s_axis: sa, s_side: ss, e_axis: ea, e_side: es,
              s_draw: sd, e_draw: ed, m_draw: md, row: row, col: col};
        return c;
    endfunction

    function automatic maze_cmd_t rand_cmd();
        maze_cmd_t c;
        int pct;
        c = mk_cmd(ACT_STEP, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 63), $urandom_range(0, 63));
        pct = $urandom_range(0, 99);
        if (!(carving && stk_cnt > 0)) begin
            if (pct < 80) c.action = ACT_START;
            else if (pct < 90) c.action = ACT_READ;
            else if (pct < 95) c.action = ACT_STEP;
            else c.action = ACT_BOGUS;
        end else if (pct < 72) begin
            c.action = ACT_STEP;
        end else if (pct < 90) begin
            c.action = ACT_READ;
            if (pct < 86) begin
                c.row = $urandom_range(0, act_side - 1);
                c.col = $urandom_range(0, act_side - 1);
            end
        end else if (pct < 96) begin
            c.action = ACT_START;
        end else begin
            c.action = ACT_BOGUS;
        end
        // mostly valid borders on starts, some same-border rejects
        if (c.action == ACT_START && c.s_axis == c.e_axis && c.s_side == c.e_side &&
            $urandom_range(0, 3) != 0)
            c.e_side = ~c.s_side;
        return c;
    endfunction

    task automatic send_cmd(maze_cmd_t c, bit typed, maze_resp_t typed_resp);
        maze_resp_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= c.action;
        i_start_axis <= c.s_axis;
        i_start_side <= c.s_side;
        i_end_axis   <= c.e_axis;
        i_end_side   <= c.e_side;
        i_start_draw <= c.s_draw;
        i_end_draw   <= c.e_draw;
        i_move_draw  <= c.m_draw;
        i_row        <= c.row;
        i_col        <= c.col;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_carve(c);
        pending_resp.insert(pending_resp.size(), typed ? typed_resp : r);
        n_items++;
    endtask

    task automatic write_side(int v);
        i_in_valid <= 1'b0;
        wait (pending_resp.size() == 0);
        repeat (4) @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_side_length <= CFG_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        side_reg = v;
        n_cfg++;
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        maze_resp_t e;
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_resp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: status %0d pos (%0d,%0d) wall %0d",
                             o_status, o_pos_x, o_pos_y, o_wall);
            end else begin
                e = pending_resp.pop_front();
                n_checked++;
                n_status[e.status]++;
                if (o_status !== e.status || o_pos_x !== e.px || o_pos_y !== e.py ||
                    o_wall !== e.wall) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch on transaction %0d: expected status %0d ",
                                  "pos (%0d,%0d) wall %0d, got status %0d ",
                                  "pos (%0d,%0d) wall %0d"},
                                 n_checked, e.status, e.px, e.py, e.wall,
                                 o_status, o_pos_x, o_pos_y, o_wall);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout with %0d transactions outstanding", pending_resp.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        dir_row_t dir_tbl [$];
        maze_resp_t none;
        int sides [8];
        none = '{status: ST_IGNORED, px: '0, py: '0, wall: 1'b0};
        cycles = 0; mismatches = 0; n_checked = 0; n_items = 0; n_cfg = 0;
        foreach (n_status[i]) n_status[i] = 0;
        foreach (grid[i]) grid[i] = WALL_F;
        stk_cnt = 0; first_mv = 1'b1; carving = 1'b0; act_side = 5; side_reg = 5;
        send_idle_pct = 22; recv_idle_pct = 63;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_action <= ACT_READ;
        {i_start_axis, i_start_side, i_end_axis, i_end_side} <= '0;
        {i_start_draw, i_end_draw, i_move_draw} <= '0;
        {i_row, i_col} <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_side_length <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle-state cases, then a small maze carved to its end
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                                         '{ST_READ, 6'd0, 6'd0, 1'b1}});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0, 65535, 0, 0), 1,
                                         none});
        dir_tbl.insert(dir_tbl.size(),
                       '{mk_cmd(ACT_BOGUS, 1, 1, 1, 1, 65535, 65535, 65535, 63, 63), 1,
                         none});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_START, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                                         '{ST_REJECTED, 6'd0, 6'd0, 1'b0}});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 63, 63), 1,
                                         '{ST_READ, 6'd0, 6'd0, 1'b1}});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_START, 0, 0, 1, 1, 65535, 0, 0, 0, 0), 1,
                                         '{ST_STARTED, 6'd1, 6'd0, 1'b0}});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0,
                                         none});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 1, 4), 0,
                                         none});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0,
                                         none});
        for (int i = 0; i < 8; i++)
            dir_tbl.insert(dir_tbl.size(),
                           '{mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0, i[0] ? 65535 : i, 0, 0),
                             0, none});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 1, 1), 0,
                                         none});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 5, 0), 0,
                                         none});
        dir_tbl.insert(dir_tbl.size(), '{mk_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 4, 3), 0,
                                         none});
        foreach (dir_tbl[i]) send_cmd(dir_tbl[i].cmd, dir_tbl[i].typed, dir_tbl[i].resp);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 63 : 0;
            recv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 22 : 0;
            sides = '{0, 63, 4, 7, 10, 13, 1, $urandom_range(0, 21)};
            foreach (sides[s]) begin
                write_side(sides[s]);
                for (int n = 0; n < PER_SIDE; n++) send_cmd(rand_cmd(), 0, none);
            end
        end
        i_in_valid <= 1'b0;

        wait (pending_resp.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("%0d transactions checked over %0d side settings: %0d started, %0d moved,",
                 n_checked, n_cfg, n_status[ST_STARTED], n_status[ST_MOVED]);
        $display("%0d backtracked, %0d finished, %0d rejected, %0d reads, %0d ignored",
                 n_status[ST_BACK], n_status[ST_FINISHED], n_status[ST_REJECTED],
                 n_status[ST_READ], n_status[ST_IGNORED]);
        if (mismatches == 0 && pending_resp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
